### hw/rtl/rimp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rimp_pkg
// Shared types and constants for the interleaved RTP media packetizer.
// ----------------------------------------------------------------------------
package rimp_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_MAX_PAYLOAD       = 3'd0,
    REG_VIDEO_SSRC        = 3'd1,
    REG_AUDIO_SSRC        = 3'd2,
    REG_VIDEO_CHANNEL     = 3'd3,
    REG_AUDIO_CHANNEL     = 3'd4,
    REG_VIDEO_MARKER_TYPE = 3'd5,
    REG_AUDIO_MARKER_TYPE = 3'd6
  } reg_index_t;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [15:0] RST_MAX_PAYLOAD       = 16'd1400;
  localparam logic [31:0] RST_VIDEO_SSRC        = 32'h5566_7788;
  localparam logic [31:0] RST_AUDIO_SSRC        = 32'h6677_8899;
  localparam logic [7:0]  RST_VIDEO_CHANNEL     = 8'd0;
  localparam logic [7:0]  RST_AUDIO_CHANNEL     = 8'd2;
  localparam logic [7:0]  RST_VIDEO_MARKER_TYPE = 8'h60;
  localparam logic [7:0]  RST_AUDIO_MARKER_TYPE = 8'hE1;

  localparam logic [15:0] MIN_PAYLOAD = 16'd3;

  localparam logic [7:0] SYNC_BYTE   = 8'h24;
  localparam logic [7:0] RTP_VERSION = 8'h80;
  localparam logic [7:0] FU_START    = 8'h80;
  localparam logic [7:0] FU_END      = 8'h40;
  localparam logic [7:0] FU_MIDDLE   = 8'h00;
  localparam logic [7:0] FU_NRI_MASK = 8'hE0;
  localparam logic [7:0] FU_TYP_MASK = 8'h1F;
  localparam logic [7:0] FU_A_TYPE   = 8'd28;
  localparam logic [7:0] AU_HDR_HI   = 8'h00;
  localparam logic [7:0] AU_HDR_LO   = 8'h10;

  localparam logic [15:0] RTP_HDR_LEN  = 16'd12;
  localparam logic [15:0] FU_FRAME_ADD = 16'd14;
  localparam logic [15:0] AU_FRAME_ADD = 16'd16;

  typedef struct packed {
    logic [15:0] max_payload;
    logic [31:0] video_ssrc;
    logic [31:0] audio_ssrc;
    logic [7:0]  video_channel;
    logic [7:0]  audio_channel;
    logic [7:0]  video_marker_type;
    logic [7:0]  audio_marker_type;
  } cfg_t;

  // one burst of output bytes caused by one input item
  typedef struct packed {
    logic        hdr;
    logic        fu;
    logic        au;
    logic        pay;
    logic        frame_end;
    logic [7:0]  channel;
    logic [15:0] flen;
    logic [7:0]  mt;
    logic [15:0] seq;
    logic [31:0] ts;
    logic [31:0] ssrc;
    logic [7:0]  fu_ind;
    logic [7:0]  fu_hdr;
    logic [12:0] au_len;
    logic [7:0]  data;
  } burst_t;

endpackage

### hw/rtl/rimp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rimp_ctrl
// Per-unit framing state; turns each accepted byte into a burst descriptor.
// ----------------------------------------------------------------------------
module rimp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       payload_byte,
  input  logic             unit_start,
  input  logic [15:0]      unit_length,
  input  logic             is_audio,
  input  logic [31:0]      timestamp,
  input  rimp_pkg::cfg_t   cfg,
  output logic             load,
  output rimp_pkg::burst_t burst
);

  logic [15:0] video_seq;
  logic [15:0] audio_seq;
  logic [15:0] unit_remaining;
  logic [15:0] fragment_fill;
  logic [7:0]  saved_nal_header;
  logic [31:0] saved_timestamp;
  logic        unit_is_audio;
  logic        unit_fragmented;

  logic [15:0] unit_remaining_next;
  logic [15:0] fragment_fill_next;
  logic [7:0]  saved_nal_header_next;
  logic [31:0] saved_timestamp_next;
  logic        unit_is_audio_next;
  logic        unit_fragmented_next;

  logic [15:0] m;
  logic        strm;
  logic [7:0]  nal;
  logic        hdr;
  logic        fu;
  logic        au;
  logic        pay;
  logic [15:0] flen;
  logic [7:0]  mark;
  logic [15:0] fill_cur;
  logic [15:0] rem_cur;

  assign m    = (cfg.max_payload < rimp_pkg::MIN_PAYLOAD) ? rimp_pkg::MIN_PAYLOAD
                                                          : cfg.max_payload;
  assign strm = unit_start ? is_audio : unit_is_audio;
  assign nal  = unit_start ? payload_byte : saved_nal_header;

  always_comb begin
    unit_remaining_next   = unit_remaining;
    fragment_fill_next    = fragment_fill;
    saved_nal_header_next = saved_nal_header;
    saved_timestamp_next  = saved_timestamp;
    unit_is_audio_next    = unit_is_audio;
    unit_fragmented_next  = unit_fragmented;
    hdr      = 1'b0;
    fu       = 1'b0;
    au       = 1'b0;
    pay      = 1'b0;
    flen     = '0;
    mark     = rimp_pkg::FU_MIDDLE;
    fill_cur = fragment_fill;
    rem_cur  = unit_remaining;
    if (unit_start) begin
      unit_remaining_next  = '0;
      fragment_fill_next   = '0;
      unit_fragmented_next = 1'b0;
      if (unit_length != 16'd0) begin
        unit_is_audio_next   = is_audio;
        saved_timestamp_next = timestamp;
        if (is_audio) begin
          hdr      = 1'b1;
          au       = 1'b1;
          pay      = 1'b1;
          flen     = unit_length + rimp_pkg::AU_FRAME_ADD;
          fill_cur = unit_length;
          rem_cur  = unit_length;
        end else if (unit_length <= m) begin
          hdr      = 1'b1;
          pay      = 1'b1;
          flen     = unit_length + rimp_pkg::RTP_HDR_LEN;
          fill_cur = unit_length;
          rem_cur  = unit_length;
        end else begin
          saved_nal_header_next = payload_byte;
          unit_fragmented_next  = 1'b1;
          hdr                   = 1'b1;
          fu                    = 1'b1;
          mark                  = rimp_pkg::FU_START;
          flen                  = m + rimp_pkg::RTP_HDR_LEN;
          unit_remaining_next   = unit_length - 16'd1;
          fragment_fill_next    = m - 16'd2;
        end
      end
    end else if (unit_remaining != 16'd0) begin
      if (fragment_fill == 16'd0) begin
        if (!unit_fragmented) begin
          unit_remaining_next = '0;
        end else begin
          hdr = 1'b1;
          fu  = 1'b1;
          pay = 1'b1;
          if (({1'b0, unit_remaining} + 17'd2) <= {1'b0, m}) begin
            flen     = unit_remaining + rimp_pkg::FU_FRAME_ADD;
            mark     = rimp_pkg::FU_END;
            fill_cur = unit_remaining;
          end else begin
            flen     = m + rimp_pkg::RTP_HDR_LEN;
            mark     = rimp_pkg::FU_MIDDLE;
            fill_cur = m - 16'd2;
          end
        end
      end else begin
        pay = 1'b1;
      end
    end
    if (pay) begin
      fragment_fill_next  = fill_cur - 16'd1;
      unit_remaining_next = rem_cur - 16'd1;
    end
  end

  always_comb begin
    burst.hdr       = hdr;
    burst.fu        = fu;
    burst.au        = au;
    burst.pay       = pay;
    burst.frame_end = (fill_cur == 16'd1);
    burst.channel   = strm ? cfg.audio_channel : cfg.video_channel;
    burst.flen      = flen;
    burst.mt        = strm ? cfg.audio_marker_type : cfg.video_marker_type;
    burst.seq       = strm ? audio_seq : video_seq;
    burst.ts        = saved_timestamp_next;
    burst.ssrc      = strm ? cfg.audio_ssrc : cfg.video_ssrc;
    burst.fu_ind    = (nal & rimp_pkg::FU_NRI_MASK) | rimp_pkg::FU_A_TYPE;
    burst.fu_hdr    = mark | (nal & rimp_pkg::FU_TYP_MASK);
    burst.au_len    = unit_length[12:0];
    burst.data      = payload_byte;
  end

  assign load = accept && (hdr || pay);

  always_ff @(posedge clk) begin
    if (rst) begin
      video_seq        <= '0;
      audio_seq        <= '0;
      unit_remaining   <= '0;
      fragment_fill    <= '0;
      saved_nal_header <= '0;
      saved_timestamp  <= '0;
      unit_is_audio    <= 1'b0;
      unit_fragmented  <= 1'b0;
    end else if (accept) begin
      unit_remaining   <= unit_remaining_next;
      fragment_fill    <= fragment_fill_next;
      saved_nal_header <= saved_nal_header_next;
      saved_timestamp  <= saved_timestamp_next;
      unit_is_audio    <= unit_is_audio_next;
      unit_fragmented  <= unit_fragmented_next;
      if (hdr && strm) begin
        audio_seq <= audio_seq + 16'd1;
      end
      if (hdr && !strm) begin
        video_seq <= video_seq + 16'd1;
      end
    end
  end

  a_seq_only_on_header: assert property (@(posedge clk) disable iff (rst)
    (accept && !hdr) |=> ($stable(video_seq) && $stable(audio_seq)))
    else $error("sequence number moved without a frame header");

endmodule

### hw/rtl/rimp_ser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rimp_ser
// Holds one burst descriptor and sends its bytes out one per request.
// ----------------------------------------------------------------------------
module rimp_ser (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  rimp_pkg::burst_t burst,
  output logic             ready,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,
  output logic             m_tlast,
  output logic             m_tuser
);

  localparam logic [4:0] POS_HDR = 5'd0;
  localparam logic [4:0] POS_HDR_END = 5'd15;
  localparam logic [4:0] POS_FU = 5'd16;
  localparam logic [4:0] POS_FU_END = 5'd17;
  localparam logic [4:0] POS_AU = 5'd18;
  localparam logic [4:0] POS_AU_END = 5'd21;
  localparam logic [4:0] POS_PAY = 5'd22;

  logic             busy;
  logic [4:0]       pos;
  rimp_pkg::burst_t d;
  logic [4:0]       nxt;
  logic             last;

  function automatic logic [4:0] first_pos(input rimp_pkg::burst_t b);
    logic [4:0] p;
    if (b.hdr) begin
      p = POS_HDR;
    end else if (b.fu) begin
      p = POS_FU;
    end else if (b.au) begin
      p = POS_AU;
    end else begin
      p = POS_PAY;
    end
    return p;
  endfunction

  always_comb begin
    if (pos == POS_HDR_END) begin
      nxt = d.fu ? POS_FU : (d.au ? POS_AU : POS_PAY);
    end else if (pos == POS_FU_END || pos == POS_AU_END || pos == POS_PAY) begin
      nxt = POS_PAY;
    end else begin
      nxt = pos + 5'd1;
    end
  end

  assign last = (pos == POS_PAY) || (nxt == POS_PAY && !d.pay);

  always_comb begin
    case (pos)
      5'd0:    m_tdata = rimp_pkg::SYNC_BYTE;
      5'd1:    m_tdata = d.channel;
      5'd2:    m_tdata = d.flen[15:8];
      5'd3:    m_tdata = d.flen[7:0];
      5'd4:    m_tdata = rimp_pkg::RTP_VERSION;
      5'd5:    m_tdata = d.mt;
      5'd6:    m_tdata = d.seq[15:8];
      5'd7:    m_tdata = d.seq[7:0];
      5'd8:    m_tdata = d.ts[31:24];
      5'd9:    m_tdata = d.ts[23:16];
      5'd10:   m_tdata = d.ts[15:8];
      5'd11:   m_tdata = d.ts[7:0];
      5'd12:   m_tdata = d.ssrc[31:24];
      5'd13:   m_tdata = d.ssrc[23:16];
      5'd14:   m_tdata = d.ssrc[15:8];
      5'd15:   m_tdata = d.ssrc[7:0];
      5'd16:   m_tdata = d.fu_ind;
      5'd17:   m_tdata = d.fu_hdr;
      5'd18:   m_tdata = rimp_pkg::AU_HDR_HI;
      5'd19:   m_tdata = rimp_pkg::AU_HDR_LO;
      5'd20:   m_tdata = d.au_len[12:5];
      5'd21:   m_tdata = {d.au_len[4:0], 3'b000};
      5'd22:   m_tdata = d.data;
      default: m_tdata = d.data;
    endcase
  end

  assign m_tvalid = busy;
  assign m_tlast  = (pos == POS_PAY) && d.frame_end;
  assign m_tuser  = last;
  assign ready    = !busy || (m_tready && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= POS_HDR;
    end else if (load) begin
      busy <= 1'b1;
      pos  <= first_pos(burst);
    end else if (busy && m_tready) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        pos <= nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      d <= burst;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> (!busy || (m_tready && last)))
    else $error("burst loaded over one still in flight");

  a_stall_holds_pos: assert property (@(posedge clk) disable iff (rst)
    (busy && !m_tready) |=> $stable(pos))
    else $error("byte position moved during a stall");

  a_drain_idle: assert property (@(posedge clk) disable iff (rst)
    (busy && m_tready && last && !load) |=> !busy)
    else $error("burst not released after its last byte");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (pos <= POS_PAY))
    else $error("byte position out of range");

endmodule

### hw/rtl/rtp_interleaved_media_packetizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_interleaved_media_packetizer
// Packs H.264 and AAC units into RTP-over-interleaved-TCP frames.
//
// channel  dir  signals                        contents
// s_       in   tvalid tready tdata tuser      media byte, length, timestamp, flags
// m_       out  tvalid tready tdata tlast tuser stream byte, frame end, item end
// cfg_     in   we index data                  register writes, no read-back
//
// one input byte is taken per cycle while it causes a single output byte
// and m_tready is high; a byte that opens a frame causes up to 21 output bytes,
// one per cycle while m_tready is high, so input stalls until they have left
// the descriptor register lets a new byte in on the cycle its last byte leaves
// reset is synchronous and clears stream state and registers to defaults
// ----------------------------------------------------------------------------
module rtp_interleaved_media_packetizer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [55:0]                       s_tdata,  // payload_byte, unit_length, timestamp
  input  logic [1:0]                        s_tuser,  // unit_start, is_audio
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [7:0]                        m_tdata,  // out_byte
  output logic                              m_tlast,
  output logic                              m_tuser,  // last_of_item
  input  logic                              cfg_we,
  input  logic [rimp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rimp_pkg::CFG_DATA_W-1:0]   cfg_data
);

  rimp_pkg::cfg_t   cfg;
  rimp_pkg::burst_t burst;
  logic             accept;
  logic             load;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_payload       <= rimp_pkg::RST_MAX_PAYLOAD;
      cfg.video_ssrc        <= rimp_pkg::RST_VIDEO_SSRC;
      cfg.audio_ssrc        <= rimp_pkg::RST_AUDIO_SSRC;
      cfg.video_channel     <= rimp_pkg::RST_VIDEO_CHANNEL;
      cfg.audio_channel     <= rimp_pkg::RST_AUDIO_CHANNEL;
      cfg.video_marker_type <= rimp_pkg::RST_VIDEO_MARKER_TYPE;
      cfg.audio_marker_type <= rimp_pkg::RST_AUDIO_MARKER_TYPE;
    end else if (cfg_we) begin
      case (cfg_index)
        rimp_pkg::REG_MAX_PAYLOAD:       cfg.max_payload       <= cfg_data[15:0];
        rimp_pkg::REG_VIDEO_SSRC:        cfg.video_ssrc        <= cfg_data;
        rimp_pkg::REG_AUDIO_SSRC:        cfg.audio_ssrc        <= cfg_data;
        rimp_pkg::REG_VIDEO_CHANNEL:     cfg.video_channel     <= cfg_data[7:0];
        rimp_pkg::REG_AUDIO_CHANNEL:     cfg.audio_channel     <= cfg_data[7:0];
        rimp_pkg::REG_VIDEO_MARKER_TYPE: cfg.video_marker_type <= cfg_data[7:0];
        rimp_pkg::REG_AUDIO_MARKER_TYPE: cfg.audio_marker_type <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign accept = s_tvalid && s_tready;

  rimp_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .payload_byte (s_tdata[7:0]),
    .unit_start   (s_tuser[0]),
    .unit_length  (s_tdata[23:8]),
    .is_audio     (s_tuser[1]),
    .timestamp    (s_tdata[55:24]),
    .cfg          (cfg),
    .load         (load),
    .burst        (burst)
  );

  rimp_ser u_ser (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .burst    (burst),
    .ready    (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule
